### rtl/counted_enable_interrupt_controller_defines.svh
// ----------------------------------------------------------------------------
// Counted-enable interrupt controller assertion macros
// Shared concurrent assertion forms, clocked by clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COUNTED_ENABLE_INTERRUPT_CONTROLLER_DEFINES_SVH
`define COUNTED_ENABLE_INTERRUPT_CONTROLLER_DEFINES_SVH

// Same-cycle implication: whenever a holds, b holds in that cycle.
`define CEI_ASSERT_IMPLY(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("cei: same-cycle check failed");

// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define CEI_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("cei: next-cycle check failed");

`endif

### rtl/cei_pkg.sv
// ----------------------------------------------------------------------------
// Counted-enable interrupt controller package
// Sizes, codes, entry layout and control structs shared by the block.
// ----------------------------------------------------------------------------
package cei_pkg;

   // Block sizing.
   localparam int NUM_SOURCES = 64;
   localparam int MAX_ENABLES = 7;
   localparam int VECTOR_BITS = 12;
   localparam int SRC_BITS    = $clog2(NUM_SOURCES);
   localparam int ENABLE_BITS = $clog2(MAX_ENABLES + 1);
   localparam int TOTAL_BITS  = $clog2(NUM_SOURCES) + 1;
   localparam int MODE_BITS   = 2;
   localparam int MASK_BITS   = 4;

   // The pending search looks at one group of sources per cycle.
   localparam int CHUNK          = 8;
   localparam int CHUNK_BITS     = $clog2(CHUNK);
   localparam int NUM_CHUNKS     = NUM_SOURCES / CHUNK;
   localparam int CHUNK_CNT_BITS = $clog2(NUM_CHUNKS);

   // The shared step unit is wide enough for the count and the total.
   localparam int ALU_BITS = (TOTAL_BITS > ENABLE_BITS) ? TOTAL_BITS : ENABLE_BITS;

   localparam logic [MASK_BITS-1:0]   MASK_ALL     = 4'hF;
   localparam logic [ENABLE_BITS-1:0] MAX_REQUIRED = ENABLE_BITS'(MAX_ENABLES);
   localparam logic [ALU_BITS-1:0]    ENABLE_LIMIT = ALU_BITS'(MAX_ENABLES);
   localparam logic [ALU_BITS-1:0]    TOTAL_LIMIT  = ALU_BITS'(NUM_SOURCES);

   // Request modes.
   typedef enum logic [MODE_BITS-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_LEVEL  = 2'd1,
      MODE_ADJUST = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_TOTAL,
      ST_SCAN,
      ST_FETCH
   } state_type;

   // One source entry as kept in the source memory.
   typedef struct packed {
      logic                   asserted;
      logic                   pending;
      logic [ENABLE_BITS-1:0] enable;
      logic [ENABLE_BITS-1:0] required;
      logic [VECTOR_BITS-1:0] vector;
   } entry_type;

   // Source memory command.
   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [SRC_BITS-1:0] addr;
      entry_type           wdata;
   } store_cmd_type;

   // Pending scanner control.
   typedef struct packed {
      logic                clear;
      logic                advance;
      logic                set_en;
      logic [SRC_BITS-1:0] set_addr;
      logic                set_value;
   } scan_ctrl_type;

   // Pending scanner status.
   typedef struct packed {
      logic                hit;
      logic                last;
      logic [SRC_BITS-1:0] index;
   } scan_stat_type;

   // One result.
   typedef struct packed {
      logic                   irq_line;
      logic                   vector_valid;
      logic [VECTOR_BITS-1:0] vector;
      logic                   none_pending;
   } rsp_type;

   // Widen an enable count to the step unit width.
   function automatic logic [ALU_BITS-1:0] enable_to_alu(input logic [ENABLE_BITS-1:0] v);
      return ALU_BITS'(v);
   endfunction

   // Widen the pending total to the step unit width.
   function automatic logic [ALU_BITS-1:0] total_to_alu(input logic [TOTAL_BITS-1:0] v);
      return ALU_BITS'(v);
   endfunction

endpackage

### rtl/cei_alu.sv
// ----------------------------------------------------------------------------
// Saturating step unit
// Adds or removes one, holding at the limit going up and at zero going down.
// ----------------------------------------------------------------------------
module cei_alu (
   input  logic [cei_pkg::ALU_BITS-1:0] operand,
   input  logic                         up,
   input  logic [cei_pkg::ALU_BITS-1:0] limit,
   output logic [cei_pkg::ALU_BITS-1:0] result
);

   // Step with saturation at both ends.
   always_comb begin
      if (up) begin
         result = (operand < limit) ? operand + 1'b1 : operand;
      end else begin
         result = (operand != '0) ? operand - 1'b1 : operand;
      end
   end

endmodule

### rtl/cei_store.sv
// ----------------------------------------------------------------------------
// Source entry memory
// One entry per source with a written flag; an unwritten entry reads as zero.
// ----------------------------------------------------------------------------
module cei_store (
   input  logic                   clock,
   input  logic                   reset,
   input  cei_pkg::store_cmd_type cmd,
   output cei_pkg::entry_type     rd_entry
);

   cei_pkg::entry_type                   mem_ff [cei_pkg::NUM_SOURCES];
   cei_pkg::entry_type                   rd_data_ff;
   logic                                 rd_valid_ff;
   logic [cei_pkg::NUM_SOURCES-1:0]      valid_ff;

   // Memory array: one access per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff  <= mem_ff[cmd.addr];
         rd_valid_ff <= valid_ff[cmd.addr];
      end
   end

   // Written flags, cleared at reset so that every entry starts at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en) begin
         valid_ff[cmd.addr] <= 1'b1;
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/cei_scan.sv
// ----------------------------------------------------------------------------
// Pending bit scanner
// Holds one pending bit per source and finds the lowest set bit, one group
// of sources per cycle.
// ----------------------------------------------------------------------------
module cei_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  cei_pkg::scan_ctrl_type ctrl,
   output cei_pkg::scan_stat_type stat
);

   logic [cei_pkg::NUM_SOURCES-1:0]    pend_ff;
   logic [cei_pkg::CHUNK_CNT_BITS-1:0] cnt_ff;
   logic [cei_pkg::CHUNK_CNT_BITS-1:0] cnt_in;
   logic [cei_pkg::CHUNK-1:0]          chunk;
   logic [cei_pkg::CHUNK_BITS-1:0]     pos;

   // Pending bits, written one source at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (ctrl.set_en) begin
         pend_ff[ctrl.set_addr] <= ctrl.set_value;
      end
   end

   // Group counter.
   always_comb begin
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
      end else if (ctrl.advance) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Lowest set bit within the current group.
   always_comb begin
      chunk = pend_ff[cnt_ff * cei_pkg::CHUNK +: cei_pkg::CHUNK];
      pos   = '0;
      for (int i = cei_pkg::CHUNK - 1; i >= 0; i--) begin
         if (chunk[i]) begin
            pos = i[cei_pkg::CHUNK_BITS-1:0];
         end
      end
   end

   assign stat.hit   = |chunk;
   assign stat.last  = (cnt_ff == cei_pkg::CHUNK_CNT_BITS'(cei_pkg::NUM_CHUNKS - 1));
   assign stat.index = {cnt_ff, pos};

endmodule

### rtl/counted_enable_interrupt_controller.sv
// ----------------------------------------------------------------------------
// Counted-enable interrupt controller
// Loads, level changes and enable steps update one source entry (never source
// 0); a query not fully masked returns the vector of the lowest-numbered pending source.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and every request
// gives exactly one result, shown for one cycle with rsp_strobe; the result
// side cannot stall, so the user must take it in that cycle. Load, level and
// enable requests run a read, an update and a total step through one shared
// saturating step unit and the single-port source memory: busy stays high
// through the update and total states, and the result strobe is registered
// from the total state. A query with mask 15 strobes on the next cycle
// without raising busy. Any other query scans the pending bits eight sources
// per cycle, then reads the vector in a fetch state when a source is found;
// its result strobes in the first cycle with busy low. No clearing pass is
// needed after reset, so a request can be taken right away. rsp_irq_line
// reflects the pending total after the request.
// ----------------------------------------------------------------------------
module counted_enable_interrupt_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cei_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [cei_pkg::SRC_BITS-1:0]        req_source_index,
   input  logic                                req_level,
   input  logic                                req_enable_up,
   input  logic [cei_pkg::VECTOR_BITS-1:0]     req_load_vector,
   input  logic [cei_pkg::ENABLE_BITS-1:0]     req_load_required,
   input  logic [cei_pkg::MASK_BITS-1:0]       req_interrupt_mask,
   output logic                                rsp_strobe,
   output logic                                rsp_irq_line,
   output logic                                rsp_vector_valid,
   output logic [cei_pkg::VECTOR_BITS-1:0]     rsp_vector,
   output logic                                rsp_none_pending
);

   cei_pkg::state_type                state_ff, state_in;
   cei_pkg::mode_type                 mode_ff, mode_in, req_mode_cast;
   logic [cei_pkg::SRC_BITS-1:0]      src_ff, src_in;
   logic                              level_ff, level_in;
   logic                              up_ff, up_in;
   logic [cei_pkg::VECTOR_BITS-1:0]   vec_ff, vec_in;
   logic [cei_pkg::ENABLE_BITS-1:0]   req_ff, req_in;
   logic                              chg_ff, chg_in;
   logic                              newpend_ff, newpend_in;
   logic [cei_pkg::TOTAL_BITS-1:0]    total_ff, total_in;
   logic                              strobe_ff, strobe_in;
   cei_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                              accept;
   logic                              usable;
   logic                              cfg_old;
   cei_pkg::entry_type                rd_entry;
   cei_pkg::entry_type                upd_entry;
   cei_pkg::store_cmd_type            store_cmd;
   cei_pkg::scan_ctrl_type            scan_ctrl;
   cei_pkg::scan_stat_type            scan_stat;
   logic [cei_pkg::ALU_BITS-1:0]      alu_operand;
   logic                              alu_up;
   logic [cei_pkg::ALU_BITS-1:0]      alu_limit;
   logic [cei_pkg::ALU_BITS-1:0]      alu_result;

   assign req_mode_cast = cei_pkg::mode_type'(req_mode);
   assign busy          = (state_ff != cei_pkg::ST_IDLE);
   assign accept        = start && !busy;

   cei_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (store_cmd),
      .rd_entry (rd_entry)
   );

   cei_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctrl  (scan_ctrl),
      .stat  (scan_stat)
   );

   cei_alu u_alu (
      .operand (alu_operand),
      .up      (alu_up),
      .limit   (alu_limit),
      .result  (alu_result)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cei_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode_cast != cei_pkg::MODE_QUERY) begin
                  state_in = cei_pkg::ST_UPDATE;
               end else if (req_interrupt_mask != cei_pkg::MASK_ALL) begin
                  state_in = cei_pkg::ST_SCAN;
               end
            end
         end
         cei_pkg::ST_UPDATE: begin
            state_in = cei_pkg::ST_TOTAL;
         end
         cei_pkg::ST_TOTAL: begin
            state_in = cei_pkg::ST_IDLE;
         end
         cei_pkg::ST_SCAN: begin
            if (scan_stat.hit) begin
               state_in = cei_pkg::ST_FETCH;
            end else if (scan_stat.last) begin
               state_in = cei_pkg::ST_IDLE;
            end
         end
         cei_pkg::ST_FETCH: begin
            state_in = cei_pkg::ST_IDLE;
         end
         default: begin
            state_in = cei_pkg::ST_IDLE;
         end
      endcase
   end

   // Entry update for load, level and enable requests.
   always_comb begin
      usable    = (src_ff != '0);
      cfg_old   = (rd_entry.vector != '0) && (rd_entry.required != '0);
      upd_entry = rd_entry;
      case (mode_ff)
         cei_pkg::MODE_LOAD: begin
            upd_entry.vector   = vec_ff;
            upd_entry.required = (req_ff > cei_pkg::MAX_REQUIRED) ?
                                 cei_pkg::MAX_REQUIRED : req_ff;
         end
         cei_pkg::MODE_LEVEL: begin
            upd_entry.asserted = level_ff;
         end
         cei_pkg::MODE_ADJUST: begin
            if (cfg_old) begin
               upd_entry.enable = alu_result[cei_pkg::ENABLE_BITS-1:0];
            end
         end
         default: begin
            upd_entry = rd_entry;
         end
      endcase
      upd_entry.pending = upd_entry.asserted && (upd_entry.vector != '0) &&
                          (upd_entry.required != '0) &&
                          (upd_entry.enable == upd_entry.required);
   end

   // Control outputs of the sequencer.
   always_comb begin
      mode_in    = mode_ff;
      src_in     = src_ff;
      level_in   = level_ff;
      up_in      = up_ff;
      vec_in     = vec_ff;
      req_in     = req_ff;
      chg_in     = chg_ff;
      newpend_in = newpend_ff;
      total_in   = total_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;

      store_cmd.rd_en = 1'b0;
      store_cmd.wr_en = 1'b0;
      store_cmd.addr  = src_ff;
      store_cmd.wdata = upd_entry;

      scan_ctrl.clear     = 1'b0;
      scan_ctrl.advance   = 1'b0;
      scan_ctrl.set_en    = 1'b0;
      scan_ctrl.set_addr  = src_ff;
      scan_ctrl.set_value = upd_entry.pending;

      alu_operand = cei_pkg::enable_to_alu(rd_entry.enable);
      alu_up      = up_ff;
      alu_limit   = cei_pkg::ENABLE_LIMIT;

      case (state_ff)
         cei_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in         = req_mode_cast;
               src_in          = req_source_index;
               level_in        = req_level;
               up_in           = req_enable_up;
               vec_in          = req_load_vector;
               req_in          = req_load_required;
               scan_ctrl.clear = 1'b1;
               store_cmd.addr  = req_source_index;
               store_cmd.rd_en = (req_mode_cast != cei_pkg::MODE_QUERY);
               // A fully masked query answers at once.
               if ((req_mode_cast == cei_pkg::MODE_QUERY) &&
                   (req_interrupt_mask == cei_pkg::MASK_ALL)) begin
                  strobe_in           = 1'b1;
                  rsp_in.irq_line     = (total_ff != '0);
                  rsp_in.vector_valid = 1'b0;
                  rsp_in.vector       = '0;
                  rsp_in.none_pending = 1'b0;
               end
            end
         end
         cei_pkg::ST_UPDATE: begin
            store_cmd.wr_en  = usable && ((mode_ff != cei_pkg::MODE_ADJUST) || cfg_old);
            scan_ctrl.set_en = store_cmd.wr_en;
            chg_in           = store_cmd.wr_en && (upd_entry.pending != rd_entry.pending);
            newpend_in       = upd_entry.pending;
         end
         cei_pkg::ST_TOTAL: begin
            // The step unit now moves the pending total.
            alu_operand = cei_pkg::total_to_alu(total_ff);
            alu_up      = newpend_ff;
            alu_limit   = cei_pkg::TOTAL_LIMIT;
            if (chg_ff) begin
               total_in = alu_result[cei_pkg::TOTAL_BITS-1:0];
            end
            strobe_in           = 1'b1;
            rsp_in.irq_line     = (total_in != '0);
            rsp_in.vector_valid = 1'b0;
            rsp_in.vector       = '0;
            rsp_in.none_pending = 1'b0;
         end
         cei_pkg::ST_SCAN: begin
            store_cmd.addr = scan_stat.index;
            if (scan_stat.hit) begin
               store_cmd.rd_en = 1'b1;
            end else if (scan_stat.last) begin
               strobe_in           = 1'b1;
               rsp_in.irq_line     = (total_ff != '0);
               rsp_in.vector_valid = 1'b0;
               rsp_in.vector       = '0;
               rsp_in.none_pending = 1'b1;
            end else begin
               scan_ctrl.advance = 1'b1;
            end
         end
         cei_pkg::ST_FETCH: begin
            strobe_in           = 1'b1;
            rsp_in.irq_line     = (total_ff != '0);
            rsp_in.vector_valid = 1'b1;
            rsp_in.vector       = rd_entry.vector;
            rsp_in.none_pending = 1'b0;
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cei_pkg::ST_IDLE;
         total_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         total_ff  <= total_in;
         strobe_ff <= strobe_in;
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      src_ff     <= src_in;
      level_ff   <= level_in;
      up_ff      <= up_in;
      vec_ff     <= vec_in;
      req_ff     <= req_in;
      chg_ff     <= chg_in;
      newpend_ff <= newpend_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_irq_line     = rsp_ff.irq_line;
   assign rsp_vector_valid = rsp_ff.vector_valid;
   assign rsp_vector       = rsp_ff.vector;
   assign rsp_none_pending = rsp_ff.none_pending;

endmodule

### rtl/cei_checker.sv
// ----------------------------------------------------------------------------
// Counted-enable interrupt controller port checks
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`include "counted_enable_interrupt_controller_defines.svh"

module cei_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [cei_pkg::MODE_BITS-1:0]       req_mode,
   input logic                                rsp_strobe,
   input logic                                rsp_irq_line,
   input logic                                rsp_vector_valid,
   input logic [cei_pkg::VECTOR_BITS-1:0]     rsp_vector,
   input logic                                rsp_none_pending
);

   // A result transfer only happens once the block has finished its work.
   `CEI_ASSERT_IMPLY(a_strobe_not_busy, rsp_strobe, !busy)

   // An entry update always occupies the block for the following cycle.
   `CEI_ASSERT_NEXT(a_update_busy, start && !busy && (req_mode != cei_pkg::MODE_QUERY), busy)

   // A returned vector implies a pending source and a nonzero vector.
   `CEI_ASSERT_IMPLY(a_vector_pending, rsp_strobe && rsp_vector_valid, rsp_irq_line && (rsp_vector != '0))

   // An empty or non-query result carries no vector.
   `CEI_ASSERT_IMPLY(a_novector_zero, rsp_strobe && !rsp_vector_valid, rsp_vector == '0)

   // A query that finds nothing pending shows a low interrupt line and no vector.
   `CEI_ASSERT_IMPLY(a_empty_no_irq, rsp_strobe && rsp_none_pending, !rsp_irq_line && !rsp_vector_valid)

endmodule

bind counted_enable_interrupt_controller cei_checker u_cei_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_mode         (req_mode),
   .rsp_strobe       (rsp_strobe),
   .rsp_irq_line     (rsp_irq_line),
   .rsp_vector_valid (rsp_vector_valid),
   .rsp_vector       (rsp_vector),
   .rsp_none_pending (rsp_none_pending)
);
